FILE: rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared fixed-point constants, register indexes and sector codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int FRAC_BITS = 8;
    localparam int ONE       = 1 << FRAC_BITS;

    localparam int HUE_W   = 9;
    localparam int CFG_W   = 9;
    localparam int CH_W    = 8;
    localparam int IDX_W   = 2;
    localparam int REM_W   = 6;
    localparam int SECT_W  = 3;

    localparam int HUE_MAX        = 360;
    localparam int DEG_PER_SECTOR = 60;

    localparam int ONE_W = FRAC_BITS + 1;
    localparam int M_W   = FRAC_BITS + 6;
    localparam int N_W   = 2 * FRAC_BITS + 6;
    localparam int P_W   = N_W + 5;

    localparam int M_MAX = DEG_PER_SECTOR * ONE;
    localparam int N_MAX = DEG_PER_SECTOR * ONE * ONE;

    // 255 / 60 reduces to 17 / 4.
    localparam int CH_MUL   = 17;
    localparam int CH_SHIFT = 2 + 2 * FRAC_BITS;

    localparam int NUM_CH = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [IDX_W-1:0] REG_SATURATION  = 2'd0;
    localparam logic [IDX_W-1:0] REG_VALUE_LEVEL = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(ONE);

    typedef enum logic [SECT_W-1:0] {
        SECT_RED_YELLOW,
        SECT_YELLOW_GREEN,
        SECT_GREEN_CYAN,
        SECT_CYAN_BLUE,
        SECT_BLUE_MAGENTA,
        SECT_MAGENTA_RED
    } sector_t;

endpackage

`default_nettype wire

FILE: rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a hue in degrees to 8-bit red, green and blue using the
// configured saturation and value.
// ----------------------------------------------------------------------------
// The block accepts one hue every clock cycle and busy is always low. Each
// result appears with done after the register stages, in order, sector split,
// saturation multiply, value multiply and channel scaling. The receiver
// cannot stall, so results must be captured in the cycle that done is high.
// The user must write saturation and value through the configuration channel
// only while no transaction is in flight; the block does not enforce this.
`default_nettype none

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [HUE_W-1:0]  hue_deg,
    output logic                   done,
    output logic [CH_W-1:0]        red,
    output logic [CH_W-1:0]        green,
    output logic [CH_W-1:0]        blue,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0] sat_reg;
    logic [CFG_W-1:0] val_reg;
    logic [ONE_W-1:0] sat_c;
    logic [ONE_W-1:0] val_c;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic accept;

    sector_t          sect_next, sect_reg;
    logic [REM_W-1:0] rem_next, rem_reg;

    logic [REM_W-1:0] x_sel [NUM_CH];
    logic [M_W-1:0]   m_next [NUM_CH];
    logic [M_W-1:0]   m_reg  [NUM_CH];
    logic [N_W-1:0]   n_next [NUM_CH];
    logic [N_W-1:0]   n_reg  [NUM_CH];
    logic [CH_W-1:0]  ch_next [NUM_CH];
    logic [CH_W-1:0]  ch_reg  [NUM_CH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= CFG_RESET;
            val_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SATURATION:  sat_reg <= cfg_data;
                REG_VALUE_LEVEL: val_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign sat_c = (32'(sat_reg) > ONE) ? ONE_W'(ONE) : ONE_W'(sat_reg);
    assign val_c = (32'(val_reg) > ONE) ? ONE_W'(ONE) : ONE_W'(val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // Stage 1: split the hue into sector and remainder. A hue of 360 or
    // more wraps to the start of the first sector.
    always_comb
    begin
        sect_next = SECT_RED_YELLOW;
        rem_next  = '0;
        if (32'(hue_deg) >= HUE_MAX)
        begin
            sect_next = SECT_RED_YELLOW;
            rem_next  = '0;
        end
        else if (32'(hue_deg) >= 5 * DEG_PER_SECTOR)
        begin
            sect_next = SECT_MAGENTA_RED;
            rem_next  = REM_W'(hue_deg - HUE_W'(5 * DEG_PER_SECTOR));
        end
        else if (32'(hue_deg) >= 4 * DEG_PER_SECTOR)
        begin
            sect_next = SECT_BLUE_MAGENTA;
            rem_next  = REM_W'(hue_deg - HUE_W'(4 * DEG_PER_SECTOR));
        end
        else if (32'(hue_deg) >= 3 * DEG_PER_SECTOR)
        begin
            sect_next = SECT_CYAN_BLUE;
            rem_next  = REM_W'(hue_deg - HUE_W'(3 * DEG_PER_SECTOR));
        end
        else if (32'(hue_deg) >= 2 * DEG_PER_SECTOR)
        begin
            sect_next = SECT_GREEN_CYAN;
            rem_next  = REM_W'(hue_deg - HUE_W'(2 * DEG_PER_SECTOR));
        end
        else if (32'(hue_deg) >= DEG_PER_SECTOR)
        begin
            sect_next = SECT_YELLOW_GREEN;
            rem_next  = REM_W'(hue_deg - HUE_W'(DEG_PER_SECTOR));
        end
        else
        begin
            sect_next = SECT_RED_YELLOW;
            rem_next  = REM_W'(hue_deg);
        end
    end

    // Stage 2: every channel is v * (60 * ONE - s * x), where x is zero for
    // the value, the remainder for q, its complement for t and 60 for p.
    always_comb
    begin
        logic [REM_W-1:0]   full_x;
        logic [REM_W-1:0]   fall_x;
        logic [REM_W-1:0]   rise_x;
        logic [REM_W-1:0]   low_x;
        logic [ONE_W+REM_W-1:0] prod;
        full_x = '0;
        fall_x = rem_reg;
        rise_x = REM_W'(DEG_PER_SECTOR) - rem_reg;
        low_x  = REM_W'(DEG_PER_SECTOR);
        case (sect_reg)
            SECT_YELLOW_GREEN:
            begin
                x_sel[CH_RED] = fall_x; x_sel[CH_GREEN] = full_x; x_sel[CH_BLUE] = low_x;
            end
            SECT_GREEN_CYAN:
            begin
                x_sel[CH_RED] = low_x; x_sel[CH_GREEN] = full_x; x_sel[CH_BLUE] = rise_x;
            end
            SECT_CYAN_BLUE:
            begin
                x_sel[CH_RED] = low_x; x_sel[CH_GREEN] = fall_x; x_sel[CH_BLUE] = full_x;
            end
            SECT_BLUE_MAGENTA:
            begin
                x_sel[CH_RED] = rise_x; x_sel[CH_GREEN] = low_x; x_sel[CH_BLUE] = full_x;
            end
            SECT_MAGENTA_RED:
            begin
                x_sel[CH_RED] = full_x; x_sel[CH_GREEN] = low_x; x_sel[CH_BLUE] = fall_x;
            end
            default:
            begin
                x_sel[CH_RED] = full_x; x_sel[CH_GREEN] = rise_x; x_sel[CH_BLUE] = low_x;
            end
        endcase
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            prod       = (ONE_W+REM_W)'(sat_c) * (ONE_W+REM_W)'(x_sel[ch]);
            m_next[ch] = M_W'(M_MAX) - M_W'(prod);
        end
    end

    // Stage 3 multiplies by the value and stage 4 scales by 255 / (60 * ONE^2).
    always_comb
    begin
        logic [P_W-1:0] scaled;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            n_next[ch]  = N_W'(val_c) * N_W'(m_reg[ch]);
            scaled      = P_W'(n_reg[ch]) * P_W'(CH_MUL);
            ch_next[ch] = scaled[CH_SHIFT+CH_W-1:CH_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        sect_reg <= sect_next;
        rem_reg  <= rem_next;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            m_reg[ch]  <= m_next[ch];
            n_reg[ch]  <= n_next[ch];
            ch_reg[ch] <= ch_next[ch];
        end
    end

    assign done  = s4_vld_reg;
    assign red   = ch_reg[CH_RED];
    assign green = ch_reg[CH_GREEN];
    assign blue  = ch_reg[CH_BLUE];

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |=> done)
        else $error("Result strobe missing after last stage.");

    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_vld_reg |=> !done)
        else $error("Result strobe without a transaction.");

    a_m_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (32'(m_reg[CH_RED]) <= M_MAX && 32'(m_reg[CH_GREEN]) <= M_MAX
                        && 32'(m_reg[CH_BLUE]) <= M_MAX))
        else $error("Saturation term out of range.");

    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        s3_vld_reg |-> (32'(n_reg[CH_RED]) <= N_MAX && 32'(n_reg[CH_GREEN]) <= N_MAX
                        && 32'(n_reg[CH_BLUE]) <= N_MAX))
        else $error("Channel numerator out of range.");

endmodule

`default_nettype wire
